>>> rtl/core/hcc_pkg.sv
// ----------------------------------------------------------------------------
// hcc_pkg: shared definitions for the heater cycle controller
// Widths, register indexes, phase and cycle-end codes, and the structs that
// carry configuration, input items and results between the modules.
// ----------------------------------------------------------------------------
package hcc_pkg;

  // Counter and field widths
  localparam int TIME_BITS  = 27;
  localparam int LIMIT_W    = 27;
  localparam int TEMP_W     = 15;
  localparam int HYST_W     = 10;
  localparam int CMP_W      = (TIME_BITS > LIMIT_W) ? TIME_BITS : LIMIT_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 27;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEAT_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL  = 3'd4;

  // Register reset values
  localparam logic signed [TEMP_W-1:0] THRESHOLD_RST  = 15'sd1670;
  localparam logic [HYST_W-1:0]        HYSTERESIS_RST = 10'd50;
  localparam logic [LIMIT_W-1:0]       HEAT_LIMIT_RST = 27'd300000;
  localparam logic [LIMIT_W-1:0]       COOLDOWN_RST   = 27'd300000;
  localparam logic [LIMIT_W-1:0]       INTERVAL_RST   = 27'd30000;

  // Item kind
  localparam logic FUNC_TICK   = 1'b0;
  localparam logic FUNC_REPORT = 1'b1;

  // Phase codes as seen on the result channel
  localparam logic [1:0] PHASE_IDLE = 2'd0;
  localparam logic [1:0] PHASE_READ = 2'd1;
  localparam logic [1:0] PHASE_WAIT = 2'd2;
  localparam logic [1:0] PHASE_COOL = 2'd3;

  // Cycle-end codes
  localparam logic [1:0] END_NONE   = 2'd0;
  localparam logic [1:0] END_THRESH = 2'd1;
  localparam logic [1:0] END_SENSOR = 2'd2;
  localparam logic [1:0] END_TIME   = 2'd3;

  typedef struct packed {
    logic signed [TEMP_W-1:0] target_centi;
    logic [HYST_W-1:0]        margin_centi;
    logic [LIMIT_W-1:0]       heat_limit_ms;
    logic [LIMIT_W-1:0]       cooldown_ms;
    logic [LIMIT_W-1:0]       interval_ms;
  } cfg_t;

  typedef struct packed {
    logic                     func;
    logic                     sensor_ok;
    logic signed [TEMP_W-1:0] temperature_centi;
  } item_t;

  typedef struct packed {
    logic       heater_enable;
    logic       measure_request;
    logic [1:0] phase;
    logic [1:0] cycle_end;
  } result_t;

endpackage

>>> rtl/core/heater_cycle_controller_core.sv
// ----------------------------------------------------------------------------
// heater_cycle_controller_core: heater cycle sequencer top level
// Input register, sequencer and output register on stream channels.
// ----------------------------------------------------------------------------
// Each input transfer is a one millisecond tick (in_tuser = 0) or a sensor
// report (in_tuser = 1) and yields exactly one result: heater drive,
// measurement request, phase and cycle-end code. Items pass through an input
// register and an output register with the sequencer logic between them, so
// one item is taken per clock unless a low out_tready stalls the registers
// and with them the input. Each item waits in the input register, the
// sequencer moves its phase and counters on as the item leaves, and the
// result is held in the output register until taken. The user must write
// settings through the cfg port only while no item is in flight (not enforced).
module heater_cycle_controller_core (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [15:0]                      in_tdata,  // [0] sensor_ok, [15:1] temperature_centi
  input  logic                             in_tuser,  // [0] func
  // Result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [7:0]                       out_tdata, // [0] heater_enable,
                                                      // [1] measure_request,
                                                      // [3:2] phase, [5:4] cycle_end
  // Configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hcc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hcc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  hcc_pkg::cfg_t    cfg;
  hcc_pkg::item_t   s1_item_r;
  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_take;
  logic             in_xfer;
  hcc_pkg::result_t seq_result;
  hcc_pkg::result_t out_r;
  logic             out_valid_r, out_valid_nxt;

  // Configuration
  assign cfg_ready = 1'b1;

  hcc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Input stage
  assign s1_take   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_take;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_take) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r.func              <= in_tuser;
      s1_item_r.sensor_ok         <= in_tdata[0];
      s1_item_r.temperature_centi <= signed'(in_tdata[15:1]);
    end
  end

  // Sequencer
  hcc_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .advance (s1_take),
    .item    (s1_item_r),
    .result  (seq_result)
  );

  // Output register
  always_comb begin
    if (s1_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      out_r <= seq_result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_r.cycle_end, out_r.phase,
                       out_r.measure_request, out_r.heater_enable};

  // Checks
  a_heater_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_r.heater_enable ==
                    ((out_r.phase == hcc_pkg::PHASE_READ) ||
                     (out_r.phase == hcc_pkg::PHASE_WAIT))))
    else $error("heater drive does not match phase");

  a_req_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_r.measure_request) |->
      (out_r.phase == hcc_pkg::PHASE_READ && out_r.cycle_end == hcc_pkg::END_NONE))
    else $error("measurement request outside a fresh reading phase");

  a_end_cool: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_r.cycle_end != hcc_pkg::END_NONE) |->
      (out_r.phase == hcc_pkg::PHASE_COOL))
    else $error("cycle end without entering cooldown");

  a_no_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_r.phase != hcc_pkg::PHASE_IDLE))
    else $error("result left the sequencer in idle start");

endmodule

>>> rtl/core/hcc_cfg_regs.sv
// ----------------------------------------------------------------------------
// hcc_cfg_regs: configuration register file
// Holds the five sequencer settings; one indexed write per transfer.
// ----------------------------------------------------------------------------
module hcc_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [hcc_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [hcc_pkg::CFG_DATA_W-1:0]   wr_data,
  output hcc_pkg::cfg_t                    cfg
);

  hcc_pkg::cfg_t cfg_r;
  hcc_pkg::cfg_t cfg_nxt;

  // Index decode; unused indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        hcc_pkg::REG_THRESHOLD:
          cfg_nxt.target_centi = signed'(wr_data[hcc_pkg::TEMP_W-1:0]);
        hcc_pkg::REG_HYSTERESIS:
          cfg_nxt.margin_centi = wr_data[hcc_pkg::HYST_W-1:0];
        hcc_pkg::REG_HEAT_LIMIT:
          cfg_nxt.heat_limit_ms = wr_data[hcc_pkg::LIMIT_W-1:0];
        hcc_pkg::REG_COOLDOWN:
          cfg_nxt.cooldown_ms = wr_data[hcc_pkg::LIMIT_W-1:0];
        hcc_pkg::REG_INTERVAL:
          cfg_nxt.interval_ms = wr_data[hcc_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_centi  <= hcc_pkg::THRESHOLD_RST;
      cfg_r.margin_centi  <= hcc_pkg::HYSTERESIS_RST;
      cfg_r.heat_limit_ms <= hcc_pkg::HEAT_LIMIT_RST;
      cfg_r.cooldown_ms   <= hcc_pkg::COOLDOWN_RST;
      cfg_r.interval_ms   <= hcc_pkg::INTERVAL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/core/hcc_seq.sv
// ----------------------------------------------------------------------------
// hcc_seq: heater cycle sequencer
// Phase state machine with saturating heating-time and wait counters. The
// result for the presented item is combinational; state moves on advance.
// ----------------------------------------------------------------------------
module hcc_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  hcc_pkg::cfg_t    cfg,
  input  logic             advance,
  input  hcc_pkg::item_t   item,
  output hcc_pkg::result_t result
);

  localparam int TW = hcc_pkg::TEMP_W + 2;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_COOL = 4'b1000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [hcc_pkg::TIME_BITS-1:0] heat_r, heat_nxt;
  logic [hcc_pkg::TIME_BITS-1:0] wait_r, wait_nxt;

  logic [hcc_pkg::TIME_BITS-1:0] heat_inc;
  logic [hcc_pkg::TIME_BITS-1:0] wait_inc;
  logic                          is_tick;
  logic                          limit_zero;
  logic                          interval_done;
  logic                          cooldown_done;
  logic                          time_up;
  logic signed [TW-1:0]          stop_level;
  logic                          temp_high;
  logic                          req;
  logic [1:0]                    cend;

  // Saturating increments
  assign heat_inc = (heat_r == '1) ? heat_r : heat_r + hcc_pkg::TIME_BITS'(1);
  assign wait_inc = (wait_r == '1) ? wait_r : wait_r + hcc_pkg::TIME_BITS'(1);

  // Limit compares at a common width
  assign is_tick       = (item.func == hcc_pkg::FUNC_TICK);
  assign limit_zero    = (cfg.heat_limit_ms == '0);
  assign interval_done = hcc_pkg::CMP_W'(wait_inc) >= hcc_pkg::CMP_W'(cfg.interval_ms);
  assign cooldown_done = hcc_pkg::CMP_W'(wait_inc) >= hcc_pkg::CMP_W'(cfg.cooldown_ms);
  assign time_up       = hcc_pkg::CMP_W'(heat_inc) >= hcc_pkg::CMP_W'(cfg.heat_limit_ms);

  // Stop level = target - margin, two bits wider to avoid overflow
  assign stop_level = TW'(cfg.target_centi) - $signed(TW'(cfg.margin_centi));
  assign temp_high  = TW'(item.temperature_centi) >= stop_level;

  // Next state
  always_comb begin
    state_nxt = state_r;
    heat_nxt  = heat_r;
    wait_nxt  = wait_r;
    req       = 1'b0;
    cend      = hcc_pkg::END_NONE;
    unique case (state_r)
      ST_IDLE: begin
        heat_nxt = '0;
        wait_nxt = '0;
        if (limit_zero) begin
          state_nxt = ST_COOL;
          cend      = hcc_pkg::END_TIME;
        end else begin
          state_nxt = ST_READ;
          req       = 1'b1;
        end
      end
      ST_READ: begin
        if (is_tick) begin
          heat_nxt = heat_inc;
        end else begin
          wait_nxt = '0;
          if (!item.sensor_ok) begin
            state_nxt = ST_COOL;
            cend      = hcc_pkg::END_SENSOR;
          end else if (temp_high) begin
            state_nxt = ST_COOL;
            cend      = hcc_pkg::END_THRESH;
          end else begin
            state_nxt = ST_WAIT;
          end
        end
      end
      ST_WAIT: begin
        if (is_tick) begin
          heat_nxt = heat_inc;
          wait_nxt = wait_inc;
          if (interval_done) begin
            wait_nxt = '0;
            if (time_up) begin
              state_nxt = ST_COOL;
              cend      = hcc_pkg::END_TIME;
            end else begin
              state_nxt = ST_READ;
              req       = 1'b1;
            end
          end
        end
      end
      ST_COOL: begin
        if (is_tick) begin
          wait_nxt = wait_inc;
          if (cooldown_done) begin
            // New cycle starts on this same tick
            heat_nxt = '0;
            wait_nxt = '0;
            if (limit_zero) begin
              cend = hcc_pkg::END_TIME;
            end else begin
              state_nxt = ST_READ;
              req       = 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result for the presented item
  always_comb begin
    result.measure_request = req;
    result.cycle_end       = cend;
    unique case (state_nxt)
      ST_IDLE: result.phase = hcc_pkg::PHASE_IDLE;
      ST_READ: result.phase = hcc_pkg::PHASE_READ;
      ST_WAIT: result.phase = hcc_pkg::PHASE_WAIT;
      ST_COOL: result.phase = hcc_pkg::PHASE_COOL;
      default: result.phase = hcc_pkg::PHASE_IDLE;
    endcase
    result.heater_enable = (state_nxt == ST_READ) || (state_nxt == ST_WAIT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      heat_r  <= '0;
      wait_r  <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
      heat_r  <= heat_nxt;
      wait_r  <= wait_nxt;
    end
  end

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for heater_cycle_controller_core
// Ticks and sensor reports go in over the input stream with random gaps,
// results come back under random backpressure. An item-level copy of the
// sequencer predicts every result, and each result is compared field by
// field in arrival order. The settings change between runs of traffic.
// ----------------------------------------------------------------------------
module tb;

  localparam int TEMP_LO       = -4500;
  localparam int TEMP_HI       = 13000;
  localparam int HANG_LIMIT    = 2000;  // cycles with work pending but no transfer
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [1:0]                    phase;
    logic [hcc_pkg::TIME_BITS-1:0] heat_ms;
    logic [hcc_pkg::TIME_BITS-1:0] wait_ms;
  } seq_state_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [15:0]                    in_tdata = '0;   // [0] sensor_ok, [15:1] temperature_centi
  logic                           in_tuser = 1'b0; // [0] func
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [7:0]                     out_tdata;       // [0] heater_enable, [1] measure_request,
                                                   // [3:2] phase, [5:4] cycle_end
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [hcc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [hcc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Settings and sequencer state as the bench sees them
  hcc_pkg::cfg_t cfg_now;
  seq_state_t    tracked_seq;  // advanced on each input transfer
  seq_state_t    planned_seq;  // advanced as items are queued, steers stimulus

  hcc_pkg::item_t   items_to_send[$];
  hcc_pkg::result_t due_results[$];
  hcc_pkg::item_t   sent_item, next_item;
  hcc_pkg::result_t got_result, want_result;

  int items_queued = 0;
  int results_matched = 0;
  int error_count = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int in_gap = 0;
  int out_hold = 0;
  int quiet_cycles = 0;

  heater_cycle_controller_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Saturating millisecond counter
  function automatic logic [hcc_pkg::TIME_BITS-1:0] sat_bump(
      input logic [hcc_pkg::TIME_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // New heating cycle; a zero heat limit ends it on the spot
  function automatic void open_cycle(inout seq_state_t st, inout logic req,
                                     inout logic [1:0] ending);
    st.heat_ms = '0;
    st.wait_ms = '0;
    if (cfg_now.heat_limit_ms == '0) begin
      st.phase = hcc_pkg::PHASE_COOL;
      ending = hcc_pkg::END_TIME;
    end else begin
      st.phase = hcc_pkg::PHASE_READ;
      req = 1'b1;
    end
  endfunction

  // One item through the sequencer: new state and the result it yields
  function automatic hcc_pkg::result_t step_heater_cycle(inout seq_state_t st,
                                                         input hcc_pkg::item_t it);
    hcc_pkg::result_t r;
    logic             req;
    logic [1:0]       ending;
    int               reading;
    int               boundary;
    req = 1'b0;
    ending = hcc_pkg::END_NONE;
    reading = $signed(it.temperature_centi);
    boundary = $signed(cfg_now.target_centi);
    boundary = boundary - int'(cfg_now.margin_centi);
    case (st.phase)
      hcc_pkg::PHASE_IDLE: begin
        open_cycle(st, req, ending);
      end
      hcc_pkg::PHASE_READ: begin
        if (it.func == hcc_pkg::FUNC_TICK) begin
          st.heat_ms = sat_bump(st.heat_ms);
        end else if (!it.sensor_ok) begin
          ending = hcc_pkg::END_SENSOR;
          st.phase = hcc_pkg::PHASE_COOL;
          st.wait_ms = '0;
        end else if (reading >= boundary) begin
          ending = hcc_pkg::END_THRESH;
          st.phase = hcc_pkg::PHASE_COOL;
          st.wait_ms = '0;
        end else begin
          st.phase = hcc_pkg::PHASE_WAIT;
          st.wait_ms = '0;
        end
      end
      hcc_pkg::PHASE_WAIT: begin
        if (it.func == hcc_pkg::FUNC_TICK) begin
          st.heat_ms = sat_bump(st.heat_ms);
          st.wait_ms = sat_bump(st.wait_ms);
          if (st.wait_ms >= cfg_now.interval_ms) begin
            st.wait_ms = '0;
            if (st.heat_ms >= cfg_now.heat_limit_ms) begin
              ending = hcc_pkg::END_TIME;
              st.phase = hcc_pkg::PHASE_COOL;
            end else begin
              req = 1'b1;
              st.phase = hcc_pkg::PHASE_READ;
            end
          end
        end
      end
      default: begin
        if (it.func == hcc_pkg::FUNC_TICK) begin
          st.wait_ms = sat_bump(st.wait_ms);
          if (st.wait_ms >= cfg_now.cooldown_ms) open_cycle(st, req, ending);
        end
      end
    endcase
    r.heater_enable = (st.phase == hcc_pkg::PHASE_READ) || (st.phase == hcc_pkg::PHASE_WAIT);
    r.measure_request = req;
    r.phase = st.phase;
    r.cycle_end = ending;
    return r;
  endfunction

  // Reading that lands near, below or far from the stop point
  function automatic int pick_reading();
    int boundary;
    int roll;
    int v;
    boundary = $signed(cfg_now.target_centi);
    boundary = boundary - int'(cfg_now.margin_centi);
    roll = $urandom_range(99);
    if (roll < 35)
      v = int'($urandom_range(6)) + boundary - 3;
    else if (roll < 60 && boundary > TEMP_LO)
      v = TEMP_LO + int'($urandom_range(boundary - 1 - TEMP_LO));
    else if (roll < 70)
      v = ($urandom_range(1) != 0) ? TEMP_HI : TEMP_LO;
    else
      v = TEMP_LO + int'($urandom_range(TEMP_HI - TEMP_LO));
    if (v < TEMP_LO) v = TEMP_LO;
    if (v > TEMP_HI) v = TEMP_HI;
    return v;
  endfunction

  task automatic queue_item(input logic func, input logic ok, input int temp);
    hcc_pkg::item_t it;
    it.func = func;
    it.sensor_ok = ok;
    it.temperature_centi = hcc_pkg::TEMP_W'(temp);
    items_to_send.push_back(it);
    items_queued++;
    void'(step_heater_cycle(planned_seq, it));
  endtask

  // Mostly what the current phase needs, with stray reports and noise
  task automatic queue_random(input int count);
    int roll;
    logic func;
    logic ok;
    int temp;
    repeat (count) begin
      roll = $urandom_range(99);
      ok = 1'($urandom_range(1));
      temp = TEMP_LO + int'($urandom_range(TEMP_HI - TEMP_LO));
      case (planned_seq.phase)
        hcc_pkg::PHASE_IDLE: func = 1'($urandom_range(1));
        hcc_pkg::PHASE_READ: begin
          func = (roll < 70) ? hcc_pkg::FUNC_REPORT : hcc_pkg::FUNC_TICK;
          if (func == hcc_pkg::FUNC_REPORT) begin
            ok = ($urandom_range(99) >= 12);
            temp = pick_reading();
          end
        end
        default: func = (roll < 8) ? hcc_pkg::FUNC_REPORT : hcc_pkg::FUNC_TICK;
      endcase
      if ($urandom_range(99) < 4) func = 1'($urandom_range(1));
      queue_item(func, ok, temp);
    end
  endtask

  // Register write; valid stays up for a following write
  task automatic set_reg(input logic [hcc_pkg::CFG_IDX_W-1:0] idx,
                         input logic [hcc_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      hcc_pkg::REG_THRESHOLD:  cfg_now.target_centi = val[hcc_pkg::TEMP_W-1:0];
      hcc_pkg::REG_HYSTERESIS: cfg_now.margin_centi = val[hcc_pkg::HYST_W-1:0];
      hcc_pkg::REG_HEAT_LIMIT: cfg_now.heat_limit_ms = val[hcc_pkg::LIMIT_W-1:0];
      hcc_pkg::REG_COOLDOWN:   cfg_now.cooldown_ms = val[hcc_pkg::LIMIT_W-1:0];
      hcc_pkg::REG_INTERVAL:   cfg_now.interval_ms = val[hcc_pkg::LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_setting(input int thr, input int hyst, input int limit, input int cool,
                              input int intv);
    set_reg(hcc_pkg::REG_THRESHOLD, hcc_pkg::CFG_DATA_W'(hcc_pkg::TEMP_W'(thr)));
    set_reg(hcc_pkg::REG_HYSTERESIS, hcc_pkg::CFG_DATA_W'(hyst));
    set_reg(hcc_pkg::REG_HEAT_LIMIT, hcc_pkg::CFG_DATA_W'(limit));
    set_reg(hcc_pkg::REG_COOLDOWN, hcc_pkg::CFG_DATA_W'(cool));
    set_reg(hcc_pkg::REG_INTERVAL, hcc_pkg::CFG_DATA_W'(intv));
    cfg_valid <= 1'b0;
  endtask

  // Every queued item answered
  task automatic drain();
    while (results_matched != items_queued) @(posedge clk);
  endtask

  task automatic log_mismatch(input string msg);
    if (error_count < REPORT_LIMIT) $display("%s", msg);
    error_count++;
  endtask

  // Input driver: predicts on each transfer, then presents the next item
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        sent_item.func = in_tuser;
        sent_item.sensor_ok = in_tdata[0];
        sent_item.temperature_centi = in_tdata[15:1];
        due_results.push_back(step_heater_cycle(tracked_seq, sent_item));
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap != 0) begin
          in_gap <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (items_to_send.size() != 0 && $urandom_range(99) < gap_pct) begin
          in_gap <= $urandom_range(11);
          in_tvalid <= 1'b0;
        end else if (items_to_send.size() != 0) begin
          next_item = items_to_send.pop_front();
          in_tdata <= {next_item.temperature_centi, next_item.sensor_ok};
          in_tuser <= next_item.func;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_result.heater_enable = out_tdata[0];
        got_result.measure_request = out_tdata[1];
        got_result.phase = out_tdata[3:2];
        got_result.cycle_end = out_tdata[5:4];
        if (due_results.size() == 0) begin
          log_mismatch($sformatf("result with nothing due: he=%0b req=%0b phase=%0d end=%0d",
                                 got_result.heater_enable, got_result.measure_request,
                                 got_result.phase, got_result.cycle_end));
        end else begin
          want_result = due_results.pop_front();
          if (got_result.heater_enable !== want_result.heater_enable ||
              got_result.measure_request !== want_result.measure_request ||
              got_result.phase !== want_result.phase ||
              got_result.cycle_end !== want_result.cycle_end)
            log_mismatch($sformatf({"result %0d: expected he=%0b req=%0b phase=%0d end=%0d,",
                                    " got he=%0b req=%0b phase=%0d end=%0d"},
                                   results_matched, want_result.heater_enable,
                                   want_result.measure_request, want_result.phase,
                                   want_result.cycle_end, got_result.heater_enable,
                                   got_result.measure_request, got_result.phase,
                                   got_result.cycle_end));
          results_matched++;
        end
      end
      if (out_hold != 0) begin
        out_hold <= out_hold - 1;
        out_tready <= 1'b0;
      end else if ($urandom_range(99) < stall_pct) begin
        out_hold <= $urandom_range(11);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Hang detection while work is outstanding
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready) ||
        (results_matched == items_queued && !cfg_valid)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus sequence
  initial begin
    cfg_now.target_centi = hcc_pkg::THRESHOLD_RST;
    cfg_now.margin_centi = hcc_pkg::HYSTERESIS_RST;
    cfg_now.heat_limit_ms = hcc_pkg::HEAT_LIMIT_RST;
    cfg_now.cooldown_ms = hcc_pkg::COOLDOWN_RST;
    cfg_now.interval_ms = hcc_pkg::INTERVAL_RST;
    tracked_seq = '0;
    planned_seq = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    gap_pct = 15;
    stall_pct = 15;

    // Power-on values: first item is a report whose content is ignored,
    // then a reading one below the stop point and a stray report
    queue_item(hcc_pkg::FUNC_REPORT, 1'b0, TEMP_HI);
    queue_item(hcc_pkg::FUNC_TICK, 1'b1, TEMP_LO);
    queue_item(hcc_pkg::FUNC_REPORT, 1'b1, 1619);
    queue_item(hcc_pkg::FUNC_REPORT, 1'b1, TEMP_HI);
    queue_item(hcc_pkg::FUNC_TICK, 1'b0, 0);
    drain();

    // Top target and margin, tiny heat limit, zero interval and cooldown
    load_setting(TEMP_HI, 1000, 2, 0, 0);
    queue_item(hcc_pkg::FUNC_TICK, 1'b0, 0);         // interval ends, time limit hit
    queue_item(hcc_pkg::FUNC_REPORT, 1'b0, TEMP_LO); // ignored during cooldown
    queue_item(hcc_pkg::FUNC_TICK, 1'b1, 0);         // cooldown over, new cycle
    queue_item(hcc_pkg::FUNC_REPORT, 1'b1, 12000);   // exactly at the stop point
    queue_item(hcc_pkg::FUNC_TICK, 1'b1, 0);
    queue_item(hcc_pkg::FUNC_REPORT, 1'b0, 5000);    // sensor failure
    queue_item(hcc_pkg::FUNC_TICK, 1'b1, 0);
    queue_item(hcc_pkg::FUNC_REPORT, 1'b1, 11999);
    queue_item(hcc_pkg::FUNC_TICK, 1'b1, 0);         // next measurement requested
    queue_item(hcc_pkg::FUNC_TICK, 1'b0, -1);        // tick while a reading is awaited
    queue_item(hcc_pkg::FUNC_REPORT, 1'b1, TEMP_LO);
    queue_item(hcc_pkg::FUNC_TICK, 1'b1, 0);
    drain();

    // Zero heat limit: each cycle ends as it starts
    load_setting(TEMP_LO, 0, 0, 0, 0);
    queue_item(hcc_pkg::FUNC_TICK, 1'b1, 0);
    queue_item(hcc_pkg::FUNC_REPORT, 1'b1, TEMP_LO);
    queue_item(hcc_pkg::FUNC_TICK, 1'b0, TEMP_HI);
    drain();

    load_setting(TEMP_LO, 0, 5, 3, 1);
    queue_item(hcc_pkg::FUNC_TICK, 1'b1, 0);
    queue_item(hcc_pkg::FUNC_TICK, 1'b1, 0);
    queue_item(hcc_pkg::FUNC_TICK, 1'b1, 0);
    queue_item(hcc_pkg::FUNC_REPORT, 1'b1, TEMP_LO);
    drain();

    // Low and high targets, zero and wide margins, short and long limits
    gap_pct = 25;
    stall_pct = 0;
    load_setting(TEMP_LO, 0, 1000, 2, 1);
    queue_random(120);
    drain();
    gap_pct = 0;
    stall_pct = 25;
    load_setting(TEMP_HI, 1000, 86400000, 1000, 86400000);
    queue_random(60);
    drain();
    load_setting(1670, 50, 1000, 86400000, 1);
    queue_random(60);
    drain();

    // Short timings so that whole cycles come round often
    for (int p = 0; p < 10; p++) begin
      gap_pct = (p >= 8) ? 0 : 8 * int'($urandom_range(3));
      stall_pct = (p >= 8) ? 0 : 8 * int'($urandom_range(3));
      load_setting(TEMP_LO + int'($urandom_range(TEMP_HI - TEMP_LO)), $urandom_range(1000),
                   ($urandom_range(9) == 0) ? 0 : $urandom_range(40, 1),
                   $urandom_range(20), $urandom_range(8));
      queue_random(130);
      drain();
    end

    repeat (10) @(posedge clk);
    if (due_results.size() != 0)
      log_mismatch($sformatf("%0d results never arrived", due_results.size()));
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
